// File: hw/rtl/fps_pkg.sv
// ============================================================================
// fps_pkg
// Shared types and constants of the farthest point sampler: field widths,
// stream packing, configuration register indexes and the pipeline tag.
// ============================================================================
package fps_pkg;

    // Coordinate and distance widths
    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int DIST_W     = 2 * COORD_BITS + 4;

    // Sample index and run length
    localparam int IDX_W       = 10;
    localparam int SCOUNT_W    = 7;
    localparam int VCOUNT_W    = 11;
    localparam int MAX_SAMPLES = 64;

    // Stream packing
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_ADDR_W-1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_SAMPLE = 2'd2;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1024;
    localparam logic [SCOUNT_W-1:0] SCOUNT_RESET = 7'd16;
    localparam logic [IDX_W-1:0]    FIRST_RESET  = 10'd0;

    // Request kinds carried on tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Cycles from the last vertex read until the best index has settled
    localparam int DRAIN_CYCLES = 6;
    localparam int DRAIN_W      = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic [DIST_W-1:0]            dist_t;

    // Travels alongside each vertex through the distance pipeline
    typedef struct packed {
        logic valid;
        logic first;   // first pass of a run: stored distance is not yet meaningful
    } tag_t;

endpackage

// File: hw/rtl/farthest_point_sampler.sv
// ============================================================================
// farthest_point_sampler
// Load items: accepted back to back while idle.
// Start item: the first sample is shown in the next cycle; each further sample
// runs through centre read, latch, vertex walk (one vertex store read per cycle),
// distance pipeline drain and the output state; no item is taken meanwhile.
// Reset (aresetn, synchronous): registers to 1024 / 16 / 0, block idle; the
// vertex store is undefined until loaded and needs no clearing pass.
// ============================================================================
module farthest_point_sampler #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [9:0] vertex_index, [25:10] coord_x, [41:26] coord_y, [57:42] coord_z
    input  logic [fps_pkg::S_TDATA_W-1:0]       s_tdata,
    // [0] req_type
    input  logic                                s_tuser,
    // Result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [9:0] sample_index
    output logic [fps_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast,
    // Configuration writes
    input  logic                                cfg_we,
    input  logic [fps_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [fps_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import fps_pkg::*;

    localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int VW    = 3 * COORD_BITS;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CENTRE = 6'b000010,
        ST_LATCH  = 6'b000100,
        ST_WALK   = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [VCOUNT_W-1:0]  cfg_vcount_reg;
    logic [SCOUNT_W-1:0]  cfg_scount_reg;
    logic [IDX_W-1:0]     cfg_first_reg;

    logic [VW-1:0]        coord_mem [MAX_VERTICES];
    logic [VW-1:0]        coord_rd_reg;
    logic [AW-1:0]        rd_addr;
    tag_t                 rd_tag_reg;
    logic [AW-1:0]        rd_idx_reg;

    coord_t               centre_x_reg, centre_y_reg, centre_z_reg;
    logic                 centre_oob_reg;
    logic                 pass_first_reg;
    logic [CNT_W-1:0]     walk_cnt_reg, walk_cnt_next;
    logic [DRAIN_W-1:0]   drain_cnt_reg, drain_cnt_next;
    logic [SCOUNT_W-1:0]  emitted_reg, emitted_next;
    logic [IDX_W-1:0]     newest_reg, newest_next;
    logic [IDX_W-1:0]     sample_reg, sample_next;
    logic                 last_reg, last_next;

    logic                 s_accept;
    logic                 load_we;
    logic [IDX_W-1:0]     ld_idx;
    logic [CNT_W-1:0]     n_eff;
    logic [SCOUNT_W-1:0]  count_eff;

    tag_t                 d_tag;
    logic [AW-1:0]        d_idx;
    dist_t                d_dist;
    logic [AW-1:0]        best_idx;

    assign s_accept = s_tvalid && s_tready;
    assign ld_idx   = s_tdata[IDX_W-1:0];
    assign load_we  = s_accept && (s_tuser == REQ_LOAD) && (32'(ld_idx) < MAX_VERTICES);

    // Saturate the run limits
    assign n_eff = (32'(cfg_vcount_reg) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                        : CNT_W'(cfg_vcount_reg);
    assign count_eff = (32'(cfg_scount_reg) > MAX_SAMPLES) ? SCOUNT_W'(MAX_SAMPLES)
                                                           : cfg_scount_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_vcount_reg <= VCOUNT_RESET;
            cfg_scount_reg <= SCOUNT_RESET;
            cfg_first_reg  <= FIRST_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_VERTEX_COUNT: cfg_vcount_reg <= cfg_wdata;
                REG_SAMPLE_COUNT: cfg_scount_reg <= cfg_wdata[SCOUNT_W-1:0];
                REG_FIRST_SAMPLE: cfg_first_reg  <= cfg_wdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // Vertex store: loads write, the sequencer reads the centre then each vertex
    assign rd_addr = (state_reg == ST_CENTRE) ? AW'(newest_reg) : walk_cnt_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (load_we) begin
            coord_mem[AW'(ld_idx)] <= s_tdata[IDX_W +: VW];
        end
        coord_rd_reg <= coord_mem[rd_addr];
        rd_idx_reg   <= walk_cnt_reg[AW-1:0];
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        walk_cnt_next  = walk_cnt_reg;
        drain_cnt_next = drain_cnt_reg;
        emitted_next   = emitted_reg;
        newest_next    = newest_reg;
        sample_next    = sample_reg;
        last_next      = last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_tuser == REQ_START) && (count_eff != '0)) begin
                    sample_next  = cfg_first_reg;
                    newest_next  = cfg_first_reg;
                    last_next    = (count_eff == SCOUNT_W'(1));
                    emitted_next = SCOUNT_W'(1);
                    state_next   = ST_EMIT;
                end
            end
            ST_CENTRE: begin
                state_next = ST_LATCH;
            end
            ST_LATCH: begin
                walk_cnt_next  = '0;
                drain_cnt_next = '0;
                state_next     = (n_eff == '0) ? ST_DRAIN : ST_WALK;
            end
            ST_WALK: begin
                walk_cnt_next = walk_cnt_reg + CNT_W'(1);
                if (walk_cnt_next == n_eff) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                drain_cnt_next = drain_cnt_reg + DRAIN_W'(1);
                if (drain_cnt_reg == DRAIN_W'(DRAIN_CYCLES - 1)) begin
                    sample_next  = IDX_W'(best_idx);
                    newest_next  = IDX_W'(best_idx);
                    emitted_next = emitted_reg + SCOUNT_W'(1);
                    last_next    = (emitted_next == count_eff);
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    state_next = (emitted_reg == count_eff) ? ST_IDLE : ST_CENTRE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            walk_cnt_reg  <= '0;
            drain_cnt_reg <= '0;
            emitted_reg   <= '0;
            newest_reg    <= '0;
            sample_reg    <= '0;
            last_reg      <= 1'b0;
            rd_tag_reg    <= '0;
        end else begin
            state_reg        <= state_next;
            walk_cnt_reg     <= walk_cnt_next;
            drain_cnt_reg    <= drain_cnt_next;
            emitted_reg      <= emitted_next;
            newest_reg       <= newest_next;
            sample_reg       <= sample_next;
            last_reg         <= last_next;
            rd_tag_reg.valid <= (state_reg == ST_WALK);
            rd_tag_reg.first <= pass_first_reg;
        end
    end

    // Hold the centre for a whole pass; an index beyond the store reads as zero
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CENTRE) begin
            pass_first_reg <= (emitted_reg == SCOUNT_W'(1));
            centre_oob_reg <= (32'(newest_reg) >= MAX_VERTICES);
        end
        if (state_reg == ST_LATCH) begin
            centre_x_reg <= centre_oob_reg ? '0 : coord_t'(coord_rd_reg[0 +: COORD_BITS]);
            centre_y_reg <= centre_oob_reg ? '0
                                           : coord_t'(coord_rd_reg[COORD_BITS +: COORD_BITS]);
            centre_z_reg <= centre_oob_reg ? '0
                                           : coord_t'(coord_rd_reg[2*COORD_BITS +: COORD_BITS]);
        end
    end

    fps_sq_dist #(
        .AW (AW)
    ) u_sq_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .centre_x (centre_x_reg),
        .centre_y (centre_y_reg),
        .centre_z (centre_z_reg),
        .vert_x   (coord_t'(coord_rd_reg[0 +: COORD_BITS])),
        .vert_y   (coord_t'(coord_rd_reg[COORD_BITS +: COORD_BITS])),
        .vert_z   (coord_t'(coord_rd_reg[2*COORD_BITS +: COORD_BITS])),
        .in_tag   (rd_tag_reg),
        .in_idx   (rd_idx_reg),
        .out_tag  (d_tag),
        .out_idx  (d_idx),
        .out_dist (d_dist)
    );

    fps_min_store #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW)
    ) u_min_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pass_start (state_reg == ST_LATCH),
        .in_tag     (d_tag),
        .in_idx     (d_idx),
        .in_dist    (d_dist),
        .best_idx   (best_idx)
    );

    // Ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = M_TDATA_W'(sample_reg);
    assign m_tlast  = last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> ((emitted_reg != '0) && (emitted_reg <= count_eff)))
        else $error("sample count out of step with the run length");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (walk_cnt_reg < n_eff))
        else $error("vertex walk ran past the vertex count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (!rd_tag_reg.valid && !d_tag.valid))
        else $error("result shown while the distance pipeline still holds vertices");

endmodule

// File: hw/rtl/fps_sq_dist.sv
// ============================================================================
// fps_sq_dist
// Three-stage squared Euclidean distance between a vertex and the current
// centre: difference, square, sum. Tag and index travel alongside.
// ============================================================================
module fps_sq_dist #(
    parameter int AW = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  fps_pkg::coord_t  centre_x,
    input  fps_pkg::coord_t  centre_y,
    input  fps_pkg::coord_t  centre_z,
    input  fps_pkg::coord_t  vert_x,
    input  fps_pkg::coord_t  vert_y,
    input  fps_pkg::coord_t  vert_z,
    input  fps_pkg::tag_t    in_tag,
    input  logic [AW-1:0]    in_idx,
    output fps_pkg::tag_t    out_tag,
    output logic [AW-1:0]    out_idx,
    output fps_pkg::dist_t   out_dist
);
    import fps_pkg::*;

    diff_t             dx_reg, dy_reg, dz_reg;
    logic [SQ_W-1:0]   sqx_reg, sqy_reg, sqz_reg;
    dist_t             sum_reg;
    tag_t              tag1_reg, tag2_reg, tag3_reg;
    logic [AW-1:0]     idx1_reg, idx2_reg, idx3_reg;

    logic signed [2*DIFF_W-1:0] px, py, pz;

    // Squares of 17-bit differences stay below 2^32
    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;
    assign pz = dz_reg * dz_reg;

    // Advance tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end else begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    // Difference, square and sum stages
    always_ff @(posedge aclk) begin
        dx_reg   <= {vert_x[COORD_BITS-1], vert_x} - {centre_x[COORD_BITS-1], centre_x};
        dy_reg   <= {vert_y[COORD_BITS-1], vert_y} - {centre_y[COORD_BITS-1], centre_y};
        dz_reg   <= {vert_z[COORD_BITS-1], vert_z} - {centre_z[COORD_BITS-1], centre_z};
        idx1_reg <= in_idx;
        sqx_reg  <= px[SQ_W-1:0];
        sqy_reg  <= py[SQ_W-1:0];
        sqz_reg  <= pz[SQ_W-1:0];
        idx2_reg <= idx1_reg;
        sum_reg  <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg) + DIST_W'(sqz_reg);
        idx3_reg <= idx2_reg;
    end

    assign out_tag  = tag3_reg;
    assign out_idx  = idx3_reg;
    assign out_dist = sum_reg;

endmodule

// File: hw/rtl/fps_min_store.sv
// ============================================================================
// fps_min_store
// Least squared distance store: read the entry, keep the smaller of stored
// and new distance, write it back, and track the largest result of the pass.
// ============================================================================
module fps_min_store #(
    parameter int MAX_VERTICES = 1024,
    parameter int AW           = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             pass_start,
    input  fps_pkg::tag_t    in_tag,
    input  logic [AW-1:0]    in_idx,
    input  fps_pkg::dist_t   in_dist,
    output logic [AW-1:0]    best_idx
);
    import fps_pkg::*;

    dist_t         lsd_mem [MAX_VERTICES];
    dist_t         old_reg;
    dist_t         dist_a_reg;
    tag_t          tag_a_reg;
    logic [AW-1:0] idx_a_reg;
    dist_t         best_d_reg, best_d_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    dist_t         upd;

    // Read the stored entry while the new distance is registered
    always_ff @(posedge aclk) begin
        old_reg    <= lsd_mem[in_idx];
        dist_a_reg <= in_dist;
        idx_a_reg  <= in_idx;
        if (tag_a_reg.valid) begin
            lsd_mem[idx_a_reg] <= upd;
        end
    end

    // On the first pass of a run the store is taken as all ones
    always_comb begin
        if (tag_a_reg.first) begin
            upd = dist_a_reg;
        end else begin
            upd = (dist_a_reg < old_reg) ? dist_a_reg : old_reg;
        end
    end

    // Strictly larger wins, so the lowest index keeps ties
    always_comb begin
        best_d_next   = best_d_reg;
        best_idx_next = best_idx_reg;
        if (pass_start) begin
            best_d_next   = '0;
            best_idx_next = '0;
        end else if (tag_a_reg.valid && (upd > best_d_reg)) begin
            best_d_next   = upd;
            best_idx_next = idx_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg    <= '0;
            best_d_reg   <= '0;
            best_idx_reg <= '0;
        end else begin
            tag_a_reg    <= in_tag;
            best_d_reg   <= best_d_next;
            best_idx_reg <= best_idx_next;
        end
    end

    assign best_idx = best_idx_reg;

    // Consecutive read and write-back never touch the same entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        (tag_a_reg.valid && in_tag.valid) |-> (in_idx != idx_a_reg))
        else $error("read and write-back of the same distance entry overlap");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pass_start |=> (best_d_reg == '0) && (best_idx_reg == '0))
        else $error("best distance not cleared at pass start");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !pass_start |=> (best_d_reg >= $past(best_d_reg)))
        else $error("best distance fell within a pass");

endmodule
